FILE: rtl/lifo_stack_with_reverse_and_sort_unit_macros.svh
// ----------------------------------------------------------------------------
// LIFO stack unit assertion macros
// Shared concurrent assertion wrappers for the stack unit.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_REVERSE_AND_SORT_UNIT_MACROS_SVH
`define LIFO_STACK_WITH_REVERSE_AND_SORT_UNIT_MACROS_SVH

// checked only outside reset
`define LSRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LSRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/lsrs_pkg.sv
// ----------------------------------------------------------------------------
// LIFO stack unit package
// Widths, command and status codes, and cell control type.
// ----------------------------------------------------------------------------
package lsrs_pkg;

    localparam int WORD_W        = 32;
    localparam int COUNT_W       = 7;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int OUT_DATA_W    = 40;
    localparam int DEFAULT_DEPTH = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_REVERSE = 3'd3,
        CMD_SORT    = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_TAG,
        CELL_EXCH
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
        logic     use_tag;
    } t_cell_ctrl;

    typedef enum logic {
        ST_IDLE,
        ST_EXCH
    } t_state;

endpackage

FILE: rtl/lsrs_cell.sv
// ----------------------------------------------------------------------------
// LIFO stack cell
// Holds one entry and its position tag; shifts on push/pop and does an
// odd-even compare-exchange with a neighbor during reverse and sort.
// ----------------------------------------------------------------------------
module lsrs_cell #(
    parameter int K  = 0,
    parameter int AW = 6
) (
    input  logic                               i_clk,
    input  lsrs_pkg::t_cell_ctrl               i_ctrl,
    input  logic                               i_self_act,
    input  logic                               i_dn_act,
    input  logic signed [lsrs_pkg::WORD_W-1:0] i_up_value,
    input  logic        [AW-1:0]               i_up_tag,
    input  logic signed [lsrs_pkg::WORD_W-1:0] i_dn_value,
    input  logic        [AW-1:0]               i_dn_tag,
    output logic signed [lsrs_pkg::WORD_W-1:0] o_value,
    output logic        [AW-1:0]               o_tag
);
    import lsrs_pkg::*;

    localparam logic PAR    = 1'(K % 2);
    localparam logic HAS_UP = (K > 0);

    logic signed [WORD_W-1:0] r_value, n_value;
    logic        [AW-1:0]     r_tag, n_tag;
    logic                     pair_dn, pair_up, less_dn, less_up;

    // top of stack is cell 0; the target order is non-increasing key downward
    assign pair_dn = (i_ctrl.phase == PAR) && i_dn_act;
    assign pair_up = HAS_UP && (i_ctrl.phase != PAR) && i_self_act;
    assign less_dn = i_ctrl.use_tag ? (r_tag < i_dn_tag) : (r_value < i_dn_value);
    assign less_up = i_ctrl.use_tag ? (i_up_tag < r_tag) : (i_up_value < r_value);

    always_comb begin
        n_value = r_value;
        n_tag   = r_tag;
        unique case (i_ctrl.op)
            CELL_PUSH: n_value = i_up_value;
            CELL_POP:  n_value = i_dn_value;
            CELL_TAG:  n_tag   = AW'(K);
            CELL_EXCH: begin
                if (pair_dn && less_dn) begin
                    n_value = i_dn_value;
                    n_tag   = i_dn_tag;
                end else if (pair_up && less_up) begin
                    n_value = i_up_value;
                    n_tag   = i_up_tag;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_tag   <= n_tag;
    end

    assign o_value = r_value;
    assign o_tag   = r_tag;

endmodule

FILE: rtl/lifo_stack_with_reverse_and_sort_unit.sv
// ----------------------------------------------------------------------------
// LIFO stack unit with reverse and sort
// Signed word stack built as a row of cells, with in-place reverse and sort.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                  | tuser
//  s_axis   | in  | [31:0] push_value                      | [2:0] command
//  m_axis   | out | [31:0] read_value, [38:32] entry_count | [1:0] status
//
// Push, pop, peek and unknown codes: one transfer per cycle while the result
// is not stalled; the result is registered in the cycle after the command.
// Reverse and sort: result registered in the cycle after the command, then the cell row
// runs entry_count odd-even exchange rounds (one per cycle) before the next
// command is taken; with fewer than two entries no rounds run.
// Synchronous active-low reset clears the count and the output valid; no
// clearing pass. A stalled result holds; when idle, the next command is taken in the
// cycle the result leaves.
// ----------------------------------------------------------------------------
`include "lifo_stack_with_reverse_and_sort_unit_macros.svh"

module lifo_stack_with_reverse_and_sort_unit #(
    parameter int STACK_DEPTH = lsrs_pkg::DEFAULT_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lsrs_pkg::WORD_W-1:0]       s_axis_tdata,  // [31:0] push_value
    input  logic [lsrs_pkg::CMD_W-1:0]        s_axis_tuser,  // [2:0] command
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lsrs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [31:0] read_value,
                                                             // [38:32] entry_count
    output logic [lsrs_pkg::STATUS_W-1:0]     m_axis_tuser   // [1:0] status
);
    import lsrs_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_round, n_round;
    logic                     r_use_tag, n_use_tag;
    logic                     r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data, n_out_data;
    t_status                  r_out_status, n_out_status;

    t_cell_ctrl               cell_ctrl;
    logic [STACK_DEPTH-1:0]   act;
    logic signed [WORD_W-1:0] w_value [STACK_DEPTH];
    logic [AW-1:0]            w_tag   [STACK_DEPTH];

    logic                     accept, full, empty;
    t_cmd                     cmd;
    logic signed [WORD_W-1:0] rd;

    assign cmd           = t_cmd'(s_axis_tuser);
    assign full          = (r_count == CW'(STACK_DEPTH));
    assign empty         = (r_count == '0);
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    genvar k;
    generate
        for (k = 0; k < STACK_DEPTH; k++) begin : g_cell
            logic signed [WORD_W-1:0] up_value, dn_value;
            logic [AW-1:0]            up_tag, dn_tag;
            logic                     dn_act;

            assign act[k] = (r_count > CW'(k));

            if (k == 0) begin : g_top
                assign up_value = $signed(s_axis_tdata);
                assign up_tag   = '0;
            end else begin : g_mid_up
                assign up_value = w_value[k-1];
                assign up_tag   = w_tag[k-1];
            end

            if (k == STACK_DEPTH - 1) begin : g_bottom
                assign dn_value = '0;
                assign dn_tag   = '0;
                assign dn_act   = 1'b0;
            end else begin : g_mid_dn
                assign dn_value = w_value[k+1];
                assign dn_tag   = w_tag[k+1];
                assign dn_act   = act[k+1];
            end

            lsrs_cell #(
                .K  (k),
                .AW (AW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (cell_ctrl),
                .i_self_act (act[k]),
                .i_dn_act   (dn_act),
                .i_up_value (up_value),
                .i_up_tag   (up_tag),
                .i_dn_value (dn_value),
                .i_dn_tag   (dn_tag),
                .o_value    (w_value[k]),
                .o_tag      (w_tag[k])
            );
        end
    endgenerate

    always_comb begin
        n_state           = r_state;
        n_count           = r_count;
        n_round           = r_round;
        n_use_tag         = r_use_tag;
        n_out_valid       = r_out_valid && !m_axis_tready;
        n_out_data        = r_out_data;
        n_out_status      = r_out_status;
        cell_ctrl.op      = CELL_HOLD;
        cell_ctrl.phase   = r_round[0];
        cell_ctrl.use_tag = r_use_tag;
        rd                = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_status = STS_OK;
                    case (cmd)
                        CMD_PUSH: begin
                            if (full) begin
                                n_out_status = STS_FULL;
                            end else begin
                                cell_ctrl.op = CELL_PUSH;
                                n_count      = r_count + 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (empty) begin
                                rd           = '1;
                                n_out_status = STS_EMPTY;
                            end else begin
                                rd           = w_value[0];
                                cell_ctrl.op = CELL_POP;
                                n_count      = r_count - 1'b1;
                            end
                        end
                        CMD_PEEK: begin
                            if (empty) begin
                                rd           = '1;
                                n_out_status = STS_EMPTY;
                            end else begin
                                rd = w_value[0];
                            end
                        end
                        CMD_REVERSE, CMD_SORT: begin
                            if (r_count > CW'(1)) begin
                                n_state   = ST_EXCH;
                                n_round   = '0;
                                n_use_tag = (cmd == CMD_REVERSE);
                                if (cmd == CMD_REVERSE) begin
                                    cell_ctrl.op = CELL_TAG;
                                end
                            end
                        end
                        default: ;
                    endcase
                    n_out_valid = 1'b1;
                    n_out_data  = {(OUT_DATA_W - WORD_W - COUNT_W)'(0),
                                   COUNT_W'(n_count), rd};
                end
            end
            ST_EXCH: begin
                cell_ctrl.op = CELL_EXCH;
                if (r_round == r_count - 1'b1) begin
                    n_state = ST_IDLE;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_round     <= '0;
            r_use_tag   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_round     <= n_round;
            r_use_tag   <= n_use_tag;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    `LSRS_ASSERT(a_no_take_in_exch, (r_state == ST_EXCH) |-> !s_axis_tready, "transfer taken during exchange rounds")
    `LSRS_ASSERT(a_count_bound, r_count <= CW'(STACK_DEPTH), "entry count above depth")
    `LSRS_ASSERT(a_round_bound, (r_state == ST_EXCH) |-> (r_round < r_count), "exchange round beyond count")
    `LSRS_ASSERT(a_push_count, (accept && cmd == CMD_PUSH && !full) |=> (r_count == $past(r_count) + 1'b1), "push did not grow count")
    `LSRS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!m_axis_tvalid && r_state == ST_IDLE), "reset left unit busy")

endmodule
